[rtl/bmsc_pkg.sv]
// Shared constants and the beat type handed from cell to cell.
package bmsc_pkg;

	localparam int COUNT_W = 30;
	localparam int BOUND_W = 12;
	localparam logic [COUNT_W:0] PRIME_MOD = 31'd998244353;

	typedef struct packed {
		logic [COUNT_W-1:0] acc;
		logic [BOUND_W-1:0] lower;
		logic [BOUND_W-1:0] upper;
		logic               first;
		logic               last;
	} stage_beat_t;

endpackage

[rtl/bounded_monotone_sequence_counter_unit.sv]
// Counts bounded non-decreasing sequences modulo 998244353 with a chain of prefix-row cells.
// The prefix row is split into NUM_CELLS equal segments (8 cells of 512 values at the default
// span), each held in its own single-port-write RAM inside one cell. An item beat enters the
// first cell, which sweeps its segment one value per cycle and hands the running sum on to the
// next cell, then takes the next item. Items in a stream follow each other at the pace of one
// cell sweeping its segment through its RAM and then handing the beat on. Results leave in
// order through an output register. No clearing pass follows reset: each cell reads its
// segment as all ones until its first sweep has rewritten it.
module bounded_monotone_sequence_counter_unit #(
	parameter int VALUE_SPAN = 4096
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_ready,
	input  logic [bmsc_pkg::BOUND_W-1:0]    lower_bound,
	input  logic [bmsc_pkg::BOUND_W-1:0]    upper_bound,
	input  logic                            first_item,
	input  logic                            last_item,
	output logic                            count_valid,
	input  logic                            count_ready,
	output logic [bmsc_pkg::COUNT_W-1:0]    sequence_count,
	output logic                            is_final
);
	import bmsc_pkg::*;

	localparam int NUM_CELLS = (VALUE_SPAN >= 8) ? 8 : 2;
	localparam int SEG       = (VALUE_SPAN + NUM_CELLS - 1) / NUM_CELLS;
	localparam int FLY_W     = $clog2(NUM_CELLS + 3);

	logic        link_valid [NUM_CELLS+1];
	logic        link_ready [NUM_CELLS+1];
	stage_beat_t link_beat  [NUM_CELLS+1];

	logic               res_valid_q;
	logic [COUNT_W-1:0] res_count_q;
	logic               res_final_q;
	logic [FLY_W-1:0]   in_flight_q;
	logic               in_fire;
	logic               out_fire;

	assign link_valid[0]       = item_valid;
	assign item_ready          = link_ready[0];
	assign link_beat[0].acc    = '0;
	assign link_beat[0].lower  = lower_bound;
	assign link_beat[0].upper  = upper_bound;
	assign link_beat[0].first  = first_item;
	assign link_beat[0].last   = last_item;

	for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
		bmsc_cell #(
			.VALUE_SPAN (VALUE_SPAN),
			.SEG        (SEG),
			.BASE_V     (k * SEG)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (link_valid[k]),
			.up_ready (link_ready[k]),
			.up_beat  (link_beat[k]),
			.dn_valid (link_valid[k+1]),
			.dn_ready (link_ready[k+1]),
			.dn_beat  (link_beat[k+1])
		);
	end

	// The output register frees the last cell whenever its slot is empty or being drained.
	assign link_ready[NUM_CELLS] = !res_valid_q || count_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (link_ready[NUM_CELLS]) begin
			res_valid_q <= link_valid[NUM_CELLS];
		end
	end

	always_ff @(posedge clk) begin
		if (link_ready[NUM_CELLS] && link_valid[NUM_CELLS]) begin
			res_count_q <= link_beat[NUM_CELLS].acc;
			res_final_q <= link_beat[NUM_CELLS].last;
		end
	end

	assign count_valid    = res_valid_q;
	assign sequence_count = res_count_q;
	assign is_final       = res_final_q;

	assign in_fire  = item_valid && item_ready;
	assign out_fire = count_valid && count_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_flight_q <= '0;
		end else if (in_fire && !out_fire) begin
			in_flight_q <= in_flight_q + 1'b1;
		end else if (out_fire && !in_fire) begin
			in_flight_q <= in_flight_q - 1'b1;
		end
	end

	a_count_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		count_valid |-> ({1'b0, sequence_count} < PRIME_MOD))
		else $error("sequence count not reduced modulo the prime");

	a_no_orphan_result: assert property (@(posedge clk) disable iff (!arst_n)
		count_valid |-> (in_flight_q != '0))
		else $error("result beat with no item in flight");

	a_flight_bound: assert property (@(posedge clk) disable iff (!arst_n)
		in_flight_q <= FLY_W'(NUM_CELLS + 1))
		else $error("more items in flight than the chain can hold");

	a_one_per_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_flight_q == '0) |-> !count_valid)
		else $error("result beat without an accepted item");

endmodule

[rtl/bmsc_cell.sv]
// One cell of the chain: owns a segment of the prefix row and sweeps it once per item.
module bmsc_cell #(
	parameter int VALUE_SPAN = 4096,
	parameter int SEG        = 512,
	parameter int BASE_V     = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 up_valid,
	output logic                 up_ready,
	input  bmsc_pkg::stage_beat_t up_beat,
	output logic                 dn_valid,
	input  logic                 dn_ready,
	output bmsc_pkg::stage_beat_t dn_beat
);
	import bmsc_pkg::*;

	localparam int IW     = (SEG > 1) ? $clog2(SEG) : 1;
	localparam int RAW_W  = $clog2(BASE_V + SEG + VALUE_SPAN + 1);
	localparam int CMPW   = (RAW_W > BOUND_W) ? RAW_W : BOUND_W;
	localparam logic [IW-1:0] LAST_IDX = IW'(SEG - 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SWEEP = 2'd1;
	localparam logic [1:0] ST_HOLD  = 2'd2;

	logic [1:0]         state_q;
	stage_beat_t        beat_q;
	logic [IW-1:0]      rd_idx_q;
	logic               rd_done_q;
	logic               ones_q;
	logic               rd_vld_s1;
	logic [IW-1:0]      wr_idx_s1;
	logic [COUNT_W-1:0] rdata_s1;
	logic [COUNT_W-1:0] mem [SEG];

	logic               rd_en;
	logic [CMPW-1:0]    value_c;
	logic               in_range;
	logic [COUNT_W-1:0] old_c;
	logic [COUNT_W-1:0] here_c;
	logic [COUNT_W:0]   sum_c;
	logic [COUNT_W-1:0] acc_next;

	assign up_ready = (state_q == ST_IDLE);
	assign dn_valid = (state_q == ST_HOLD);
	assign dn_beat  = beat_q;
	assign rd_en    = (state_q == ST_SWEEP) && !rd_done_q;

	// Until the first sweep completes, the segment reads as all ones, as after reset.
	always_comb begin
		value_c  = CMPW'(BASE_V) + CMPW'(wr_idx_s1);
		in_range = (value_c >= CMPW'(beat_q.lower)) && (value_c <= CMPW'(beat_q.upper))
			&& (value_c < CMPW'(VALUE_SPAN));
		old_c    = (beat_q.first || ones_q) ? COUNT_W'(1) : rdata_s1;
		here_c   = in_range ? old_c : '0;
		sum_c    = {1'b0, beat_q.acc} + {1'b0, here_c};
		acc_next = (sum_c >= PRIME_MOD) ? COUNT_W'(sum_c - PRIME_MOD) : sum_c[COUNT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			beat_q    <= '0;
			rd_idx_q  <= '0;
			rd_done_q <= 1'b0;
			ones_q    <= 1'b1;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
			case (state_q)
				ST_IDLE: begin
					if (up_valid) begin
						beat_q    <= up_beat;
						rd_idx_q  <= '0;
						rd_done_q <= 1'b0;
						state_q   <= ST_SWEEP;
					end
				end
				ST_SWEEP: begin
					if (rd_en) begin
						if (rd_idx_q == LAST_IDX) begin
							rd_done_q <= 1'b1;
						end else begin
							rd_idx_q <= rd_idx_q + 1'b1;
						end
					end
					if (rd_vld_s1) begin
						beat_q.acc <= acc_next;
						if (wr_idx_s1 == LAST_IDX) begin
							ones_q  <= 1'b0;
							state_q <= ST_HOLD;
						end
					end
				end
				ST_HOLD: begin
					if (dn_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		wr_idx_s1 <= rd_idx_q;
		if (rd_en) begin
			rdata_s1 <= mem[rd_idx_q];
		end
		if (rd_vld_s1) begin
			mem[wr_idx_s1] <= acc_next;
		end
	end

endmodule

[verif/bmsc_checker.sv]
// Watches both channels of the sequence counter, predicts each count and compares it.
module bmsc_checker #(
	parameter int VALUE_SPAN = 4096
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	input  logic                            item_ready,
	input  logic [bmsc_pkg::BOUND_W-1:0]    lower_bound,
	input  logic [bmsc_pkg::BOUND_W-1:0]    upper_bound,
	input  logic                            first_item,
	input  logic                            last_item,
	input  logic                            count_valid,
	input  logic                            count_ready,
	input  logic [bmsc_pkg::COUNT_W-1:0]    sequence_count,
	input  logic                            is_final,
	output int                              error_count,
	output int                              awaiting
);
	timeunit 1ns;
	timeprecision 1ps;
	import bmsc_pkg::*;

	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic               is_last;
	} count_beat_t;

	logic [COUNT_W-1:0] prefix_sums [VALUE_SPAN];
	count_beat_t        expected_counts [$];
	count_beat_t        oldest;
	int                 errors = 0;
	int                 reported = 0;

	assign error_count = errors;
	assign awaiting    = expected_counts.size();

	// After reset every value may start a sequence.
	initial begin
		for (int v = 0; v < VALUE_SPAN; v++) prefix_sums[v] = COUNT_W'(1);
	end

	// Rebuilds the prefix row for one position and returns the total number of sequences.
	function automatic logic [COUNT_W-1:0] extend_sequences(input logic [BOUND_W-1:0] lo,
			input logic [BOUND_W-1:0] hi, input logic restart);
		logic [COUNT_W:0]   run_sum;
		logic [COUNT_W-1:0] ending_here;
		run_sum = '0;
		for (int v = 0; v < VALUE_SPAN; v++) begin
			ending_here = restart ? COUNT_W'(1) : prefix_sums[v];
			if (v >= int'(lo) && v <= int'(hi)) begin
				run_sum = run_sum + ending_here;
				if (run_sum >= PRIME_MOD) run_sum = run_sum - PRIME_MOD;
			end
			prefix_sums[v] = run_sum[COUNT_W-1:0];
		end
		return run_sum[COUNT_W-1:0];
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && item_ready) begin
				expected_counts.push_back('{count: extend_sequences(lower_bound, upper_bound,
					first_item), is_last: last_item});
			end
			if (count_valid && count_ready) begin
				if (expected_counts.size() == 0) begin
					errors++;
					if (reported < 10) begin
						reported++;
						$display("unexpected count beat: count %0d final %0b",
							sequence_count, is_final);
					end
				end else begin
					oldest = expected_counts.pop_front();
					if (sequence_count !== oldest.count || is_final !== oldest.is_last) begin
						errors++;
						if (reported < 10) begin
							reported++;
							$display("count mismatch: expected count %0d final %0b, got count %0d final %0b",
								oldest.count, oldest.is_last, sequence_count, is_final);
						end
					end
				end
			end
		end
	end

endmodule

[verif/tb_top.sv]
// Stimulus, clock, reset and verdict for the bounded sequence counter.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import bmsc_pkg::*;

	localparam int SPAN         = 4096;
	localparam int CYCLE_LIMIT  = 3_000_000;
	localparam int DRAIN_CYCLES = SPAN + 256;
	localparam int PHASE_ITEMS  = 30;
	localparam int MAX_BOUND    = 4095;

	logic               clk;
	logic               arst_n;
	logic               item_valid;
	logic               item_ready;
	logic [BOUND_W-1:0] lower_bound;
	logic [BOUND_W-1:0] upper_bound;
	logic               first_item;
	logic               last_item;
	logic               count_valid;
	logic               count_ready;
	logic [COUNT_W-1:0] sequence_count;
	logic               is_final;

	int check_errors;
	int results_owed;
	int sender_idle_pct = 0;
	int ready_stall_pct = 0;
	int stall_hold = 0;
	int cycle_count = 0;

	bounded_monotone_sequence_counter_unit #(.VALUE_SPAN(SPAN)) dut (.*);

	bmsc_checker #(.VALUE_SPAN(SPAN)) u_checker (
		.*,
		.error_count(check_errors),
		.awaiting(results_owed)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Receiver: random stalls with an occasional long hold on the count channel.
	initial begin
		count_ready <= 1'b0;
		forever begin
			@(negedge clk);
			if (stall_hold > 0) begin
				stall_hold--;
				count_ready <= 1'b0;
			end else if ($urandom_range(99) < ready_stall_pct) begin
				count_ready <= 1'b0;
				if ($urandom_range(255) == 0) stall_hold = $urandom_range(400, 1);
			end else begin
				count_ready <= 1'b1;
			end
		end
	end

	task automatic send_item(input int lo, input int hi, input bit head, input bit tail);
		int gap;
		if ($urandom_range(99) < sender_idle_pct) begin
			gap = ($urandom_range(31) == 0) ? $urandom_range(1200, 1) : $urandom_range(4, 1);
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid  <= 1'b1;
		lower_bound <= lo[BOUND_W-1:0];
		upper_bound <= hi[BOUND_W-1:0];
		first_item  <= head;
		last_item   <= tail;
		do @(posedge clk); while (!item_ready);
		@(negedge clk);
	endtask

	initial begin
		int phase_sent;
		int run_len;
		int lo_pick;
		int hi_pick;
		arst_n      <= 1'b0;
		item_valid  <= 1'b0;
		lower_bound <= '0;
		upper_bound <= '0;
		first_item  <= 1'b0;
		last_item   <= 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// The reset row acts as a restart even without a first beat.
		send_item(0, MAX_BOUND, 0, 0);
		send_item(0, MAX_BOUND, 0, 0);
		// A last beat does not stop the sequence from being extended.
		send_item(0, MAX_BOUND, 0, 1);
		send_item(0, MAX_BOUND, 0, 0);
		send_item(MAX_BOUND, MAX_BOUND, 1, 0);
		send_item(0, 0, 0, 1);
		send_item(0, 0, 1, 0);
		send_item(MAX_BOUND, MAX_BOUND, 0, 1);
		// Empty intervals wipe the row, and it stays empty until a restart.
		send_item(5, 4, 1, 0);
		send_item(0, MAX_BOUND, 0, 0);
		send_item(MAX_BOUND, 0, 0, 1);
		send_item('h555, 'hAAA, 1, 0);
		send_item('hAAA, MAX_BOUND, 0, 1);
		send_item(0, MAX_BOUND, 1, 1);
		send_item(100, 100, 1, 0);
		send_item(100, 100, 0, 1);
		// Full-span positions push the count well past the modulus.
		send_item(0, MAX_BOUND, 1, 0);
		for (int k = 0; k < 5; k++) send_item(0, MAX_BOUND, 0, k == 4);

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin sender_idle_pct = 0;  ready_stall_pct = 0;  end
				1: begin sender_idle_pct = 71; ready_stall_pct = 0;  end
				2: begin sender_idle_pct = 0;  ready_stall_pct = 71; end
				default: begin sender_idle_pct = 18; ready_stall_pct = 18; end
			endcase
			phase_sent = 0;
			while (phase_sent < PHASE_ITEMS) begin
				if ($urandom_range(4) == 0) begin
					send_item($urandom_range(MAX_BOUND), $urandom_range(MAX_BOUND),
						1'($urandom_range(1)), 1'($urandom_range(1)));
					phase_sent++;
				end else begin
					// Run of positions: the lower bound drifts, upward more often than down, and the upper bound is never below it.
					run_len = $urandom_range(6, 1);
					lo_pick = $urandom_range(3000);
					for (int k = 0; k < run_len; k++) begin
						if (k > 0) lo_pick = lo_pick + int'($urandom_range(300)) - 100;
						if (lo_pick < 0) lo_pick = 0;
						if (lo_pick > MAX_BOUND) lo_pick = MAX_BOUND;
						if ($urandom_range(1) == 0) begin
							hi_pick = lo_pick + int'($urandom_range(64));
							if (hi_pick > MAX_BOUND) hi_pick = MAX_BOUND;
						end else begin
							hi_pick = $urandom_range(MAX_BOUND, lo_pick);
						end
						send_item(lo_pick, hi_pick, k == 0, k == run_len - 1);
						phase_sent++;
					end
				end
			end
		end
		item_valid <= 1'b0;

		wait (results_owed == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (results_owed != 0) $display("counts still owed at end: %0d", results_owed);
		if (check_errors == 0 && results_owed == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
